// ----- sv/sawbs_pkg.sv -----
package sawbs_pkg;

   localparam int unsigned PACKET_BYTES = 1024;
   localparam logic [6:0] TIMEOUT_SECONDS = 7'd32;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_RESPONSE = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   localparam logic [3:0] ST_NONE = 4'd0;
   localparam logic [3:0] ST_CONTINUE = 4'd1;
   localparam logic [3:0] ST_DONE = 4'd2;
   localparam logic [3:0] ST_BAD_SIZE = 4'd3;
   localparam logic [3:0] ST_BAD_COMMAND = 4'd4;
   localparam logic [3:0] ST_RECV_ERROR = 4'd5;
   localparam logic [3:0] ST_BAD_OFFSET = 4'd6;
   localparam logic [3:0] ST_CANNOT_START = 4'd7;
   localparam logic [3:0] ST_TIMEOUT = 4'd8;

   localparam logic CSR_COMMAND_ID = 1'b0;
   localparam logic CSR_OUTPUT_PORT = 1'b1;

   typedef struct packed {
      logic [1:0] opcode;
      logic [30:0] image_length;
      logic image_valid;
      logic storage_open_ok;
      logic response_size_ok;
      logic [15:0] response_command;
      logic signed [31:0] response_error;
      logic [31:0] response_offset;
      logic [5:0] tick_seconds;
   } req_payload_type;

   typedef struct packed {
      logic [3:0] status;
      logic send_request;
      logic [31:0] packet_offset;
      logic [30:0] packet_total;
      logic [15:0] packet_command;
      logic [7:0] packet_port;
   } rsp_payload_type;

   typedef struct packed {
      logic [15:0] command_id;
      logic [7:0] output_port;
   } cfg_type;

endpackage

// ----- sv/sawbs_ifs.sv -----
interface sawbs_req_if;
   logic valid;
   logic ready;
   logic [1:0] opcode;
   logic [30:0] image_length;
   logic image_valid;
   logic storage_open_ok;
   logic response_size_ok;
   logic [15:0] response_command;
   logic signed [31:0] response_error;
   logic [31:0] response_offset;
   logic [5:0] tick_seconds;

   modport source (
      output valid, opcode, image_length, image_valid, storage_open_ok,
         response_size_ok, response_command, response_error, response_offset,
         tick_seconds,
      input ready
   );
   modport sink (
      input valid, opcode, image_length, image_valid, storage_open_ok,
         response_size_ok, response_command, response_error, response_offset,
         tick_seconds,
      output ready
   );
endinterface

interface sawbs_rsp_if;
   logic valid;
   logic ready;
   logic [3:0] status;
   logic send_request;
   logic [31:0] packet_offset;
   logic [30:0] packet_total;
   logic [15:0] packet_command;
   logic [7:0] packet_port;

   modport source (
      output valid, status, send_request, packet_offset, packet_total,
         packet_command, packet_port,
      input ready
   );
   modport sink (
      input valid, status, send_request, packet_offset, packet_total,
         packet_command, packet_port,
      output ready
   );
endinterface

// ----- sv/sawbs_in_stage.sv -----
module sawbs_in_stage
   import sawbs_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  req_payload_type in_data,
   output logic out_valid,
   input  logic out_ready,
   output req_payload_type out_data
);

   logic valid_ff;
   logic valid_in;
   req_payload_type data_ff;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

// ----- sv/sawbs_engine.sv -----
module sawbs_engine
   import sawbs_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  cfg_type cfg,
   input  logic in_valid,
   output logic in_ready,
   input  req_payload_type in_data,
   output logic out_valid,
   input  logic out_ready,
   output rsp_payload_type out_data
);

   logic [31:0] send_offset_ff;
   logic [31:0] send_offset_in;
   logic [30:0] total_length_ff;
   logic [30:0] total_length_in;
   logic [6:0] timer_ff;
   logic [6:0] timer_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   rsp_payload_type rsp_ff;
   rsp_payload_type rsp_in;
   logic fire;
   logic [32:0] offset_sum;
   logic [31:0] offset_next;
   logic [6:0] timer_sum;
   logic [3:0] status;
   logic send;

   assign in_ready = !rsp_valid_ff || out_ready;
   assign fire = in_valid && in_ready;

   assign offset_sum = {1'b0, send_offset_ff} + 33'(PACKET_BYTES);
   assign offset_next = offset_sum[32] ? '1 : offset_sum[31:0];
   assign timer_sum = timer_ff + {1'b0, in_data.tick_seconds};

   always_comb begin
      send_offset_in = send_offset_ff;
      total_length_in = total_length_ff;
      timer_in = timer_ff;
      status = ST_NONE;
      send = 1'b0;
      unique case (in_data.opcode)
         OP_START: begin
            if (!in_data.image_valid || !in_data.storage_open_ok) begin
               status = ST_CANNOT_START;
            end else begin
               total_length_in = in_data.image_length;
               send_offset_in = '0;
               timer_in = 7'd1;
               status = ST_CONTINUE;
               send = 1'b1;
            end
         end
         OP_RESPONSE: begin
            // Checks run in a fixed order; the first failure names the status.
            send_offset_in = '0;
            timer_in = '0;
            priority if (!in_data.response_size_ok) begin
               status = ST_BAD_SIZE;
            end else if (in_data.response_command != cfg.command_id) begin
               status = ST_BAD_COMMAND;
            end else if (in_data.response_error == '0 || in_data.response_error[31]) begin
               status = ST_RECV_ERROR;
            end else if (in_data.response_offset != send_offset_ff) begin
               status = ST_BAD_OFFSET;
            end else if (offset_next >= {1'b0, total_length_ff}) begin
               status = ST_DONE;
            end else begin
               send_offset_in = offset_next;
               timer_in = 7'd1;
               status = ST_CONTINUE;
               send = 1'b1;
            end
         end
         OP_TICK: begin
            // A zero timer means no transfer is armed, so ticks are ignored.
            if (timer_ff != '0) begin
               if (timer_sum > TIMEOUT_SECONDS) begin
                  send_offset_in = '0;
                  timer_in = '0;
                  status = ST_TIMEOUT;
               end else begin
                  timer_in = timer_sum;
               end
            end
         end
         default: begin
            status = ST_NONE;
         end
      endcase
   end

   always_comb begin
      rsp_in.status = status;
      rsp_in.send_request = send;
      rsp_in.packet_offset = send ? send_offset_in : '0;
      rsp_in.packet_total = send ? total_length_in : '0;
      rsp_in.packet_command = send ? cfg.command_id : '0;
      rsp_in.packet_port = send ? cfg.output_port : '0;
   end

   assign rsp_valid_in = fire || (rsp_valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         send_offset_ff <= '0;
         total_length_ff <= '0;
         timer_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            send_offset_ff <= send_offset_in;
            total_length_ff <= total_length_in;
            timer_ff <= timer_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_data = rsp_ff;

endmodule

// ----- sv/stop_and_wait_block_sender.sv -----
// Sender side of a stop-and-wait block download.
// The req channel carries one transaction per event: a start (image length and
// usability flags), a receiver response to check, or a seconds tick. The rsp
// channel returns exactly one transaction per request, in order, with a status
// and, when send_request is set, the header of the next packet to post.
// The csr port writes the command identifier (index 0) and the output link
// port (index 1); write it only while the block is idle.
// An accepted request passes through the input register, then through the
// decision logic that updates the offset, length and timer registers and
// loads the result register. Throughput is one transaction per cycle while
// rsp ready is not held low, set by the state update loop.
// A synchronous reset clears the offset, length, timer and both csr values and
// empties the pipeline. When the receiver holds rsp ready low, the result stays
// in its register; the input register fills behind it and then req ready drops
// until the result is taken.
module stop_and_wait_block_sender
   import sawbs_pkg::*;
(
   input  logic clock,
   input  logic reset,
   sawbs_req_if.sink req_chan,
   sawbs_rsp_if.source rsp_chan,
   input  logic csr_we,
   input  logic csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type cfg_ff;
   req_payload_type req_data;
   req_payload_type stage_data;
   rsp_payload_type rsp_data;
   logic stage_valid;
   logic stage_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COMMAND_ID: cfg_ff.command_id <= csr_wdata;
            CSR_OUTPUT_PORT: cfg_ff.output_port <= csr_wdata[7:0];
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      req_data.opcode = req_chan.opcode;
      req_data.image_length = req_chan.image_length;
      req_data.image_valid = req_chan.image_valid;
      req_data.storage_open_ok = req_chan.storage_open_ok;
      req_data.response_size_ok = req_chan.response_size_ok;
      req_data.response_command = req_chan.response_command;
      req_data.response_error = req_chan.response_error;
      req_data.response_offset = req_chan.response_offset;
      req_data.tick_seconds = req_chan.tick_seconds;
   end

   sawbs_in_stage u_in_stage (
      .clock(clock),
      .reset(reset),
      .in_valid(req_chan.valid),
      .in_ready(req_chan.ready),
      .in_data(req_data),
      .out_valid(stage_valid),
      .out_ready(stage_ready),
      .out_data(stage_data)
   );

   sawbs_engine u_engine (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .in_valid(stage_valid),
      .in_ready(stage_ready),
      .in_data(stage_data),
      .out_valid(rsp_chan.valid),
      .out_ready(rsp_chan.ready),
      .out_data(rsp_data)
   );

   assign rsp_chan.status = rsp_data.status;
   assign rsp_chan.send_request = rsp_data.send_request;
   assign rsp_chan.packet_offset = rsp_data.packet_offset;
   assign rsp_chan.packet_total = rsp_data.packet_total;
   assign rsp_chan.packet_command = rsp_data.packet_command;
   assign rsp_chan.packet_port = rsp_data.packet_port;

endmodule
